[design/dplb_pkg.sv]
// Shared types, codes and constants of the DMA page-list builder.
package dplb_pkg;

  localparam int unsigned ADDR_W     = 64;
  localparam int unsigned SEG_LEN_W  = 21;
  localparam int unsigned TAG_W      = 6;
  localparam int unsigned PIDX_W     = 8;
  localparam int unsigned STATUS_W   = 3;
  localparam int unsigned PCOUNT_W   = 9;
  localparam int unsigned OFFSET_W   = 12;

  localparam int unsigned TAG_COUNT_DEF     = 36;
  localparam int unsigned PAGES_PER_TAG_DEF = 256;
  localparam int unsigned PAGE_BYTES_DEF    = 4096;

  typedef enum logic [1:0] {
    CMD_BEGIN   = 2'd0,
    CMD_SEGMENT = 2'd1,
    CMD_RELEASE = 2'd2,
    CMD_READ    = 2'd3
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_NO_TAG   = 3'd1,
    ST_MISALIGN = 3'd2,
    ST_LEN      = 3'd3,
    ST_PAGES    = 3'd4,
    ST_NO_REQ   = 3'd5,
    ST_OPEN     = 3'd6
  } status_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LATCH,
    OP_SRCH_INIT,
    OP_SRCH_STEP,
    OP_SEG_PREP,
    OP_PAGE_WR,
    OP_RD_ADDR,
    OP_FIN_BEGIN_OPEN,
    OP_FIN_GRANT,
    OP_FIN_NO_TAG,
    OP_FIN_NO_REQ,
    OP_FIN_FAIL,
    OP_FIN_SEG_END,
    OP_FIN_RELEASE,
    OP_FIN_READ
  } dp_op_e;

  typedef struct packed {
    logic [1:0]           command;
    logic [ADDR_W-1:0]    seg_address;
    logic [SEG_LEN_W-1:0] seg_length;
    logic                 last_segment;
    logic [TAG_W-1:0]     tag;
    logic [PIDX_W-1:0]    page_index;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [TAG_W-1:0]    tag_out;
    logic [PCOUNT_W-1:0] page_count;
    logic [OFFSET_W-1:0] first_offset;
    logic [ADDR_W-1:0]   page_address;
    logic                request_done;
  } out_item_t;

  typedef struct packed {
    dp_op_e  op;
    status_e code;
  } dplb_cmd_t;

  typedef struct packed {
    cmd_e cmd;
    logic req_open;
    logic cand_free;
    logic srch_last;
    logic mis;
    logic len_bad;
    logic len_zero;
    logic pages_full;
    logic out_free;
  } dplb_sts_t;

endpackage

[design/dplb_datapath.sv]
// Datapath: tag map, request state, page table memory and result register.
module dplb_datapath #(
  parameter int unsigned TAG_COUNT     = dplb_pkg::TAG_COUNT_DEF,
  parameter int unsigned PAGES_PER_TAG = dplb_pkg::PAGES_PER_TAG_DEF,
  parameter int unsigned PAGE_BYTES    = dplb_pkg::PAGE_BYTES_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dplb_pkg::in_item_t  in_data_i,
  input  dplb_pkg::dplb_cmd_t cmd_i,
  output dplb_pkg::dplb_sts_t sts_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output dplb_pkg::out_item_t out_data_o
);
  import dplb_pkg::*;

  localparam int unsigned TW    = $clog2(TAG_COUNT);
  localparam int unsigned OW    = $clog2(PAGE_BYTES);
  localparam int unsigned FW    = ADDR_W - OW;
  localparam int unsigned PCW   = $clog2(PAGES_PER_TAG + 1);
  localparam int unsigned DEPTH = TAG_COUNT * PAGES_PER_TAG;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned LW    = SEG_LEN_W + 1;

  in_item_t         in_q;
  logic [TAG_COUNT-1:0] busy_q;
  logic [TW-1:0]    last_q;
  logic             open_q;
  logic [TW-1:0]    open_tag_q;
  logic [PCW-1:0]   pages_q;
  logic             seen_q;
  logic [OW-1:0]    held_q;
  logic [TW-1:0]    cand_q;
  logic [TW-1:0]    cnt_q;
  logic [AW-1:0]    base_q;
  logic [FW-1:0]    wa_q;
  logic [LW-1:0]    wl_q;
  logic             mis_q;
  logic             len_bad_q;
  logic [AW-1:0]    rd_addr_q;
  logic             rd_ok_q;
  logic [FW-1:0]    rd_data_q;
  logic [FW-1:0]    page_mem_q [DEPTH];
  logic             out_valid_q;
  out_item_t        out_q;

  logic             tag_in_range;
  logic             page_in_range;
  logic [TW-1:0]    tag_lo;
  logic [TW-1:0]    cand_nx;
  logic [TW-1:0]    srch_start;
  logic [OW-1:0]    seg_off;
  logic [LW-1:0]    prep_len;
  logic             prep_mis;
  logic             prep_len_bad;
  logic [LW-1:0]    wl_nx;
  logic [AW-1:0]    wr_addr;
  logic             out_free;
  logic             emit;
  out_item_t        res;

  assign tag_in_range  = 32'(in_q.tag) < TAG_COUNT;
  assign page_in_range = 32'(in_q.page_index) < PAGES_PER_TAG;
  assign tag_lo        = in_q.tag[TW-1:0];
  assign cand_nx       = (cand_q == TW'(TAG_COUNT - 1)) ? '0 : cand_q + 1'b1;
  assign srch_start    = (last_q == TW'(TAG_COUNT - 1)) ? '0 : last_q + 1'b1;
  assign seg_off       = seen_q ? '0 : in_q.seg_address[OW-1:0];
  assign prep_len      = LW'(in_q.seg_length) + LW'(seg_off);
  assign prep_mis      = seen_q && (in_q.seg_address[OW-1:0] != '0);
  assign prep_len_bad  = !in_q.last_segment && (prep_len[OW-1:0] != '0);
  assign wl_nx         = (wl_q > LW'(PAGE_BYTES)) ? wl_q - LW'(PAGE_BYTES) : '0;
  assign wr_addr       = base_q + AW'(pages_q);
  assign out_free      = !out_valid_q || out_ready_i;

  always_comb begin
    sts_o.cmd        = cmd_e'(in_q.command);
    sts_o.req_open   = open_q;
    sts_o.cand_free  = !busy_q[cand_q];
    sts_o.srch_last  = cnt_q == TW'(TAG_COUNT - 1);
    sts_o.mis        = mis_q;
    sts_o.len_bad    = len_bad_q;
    sts_o.len_zero   = wl_q == '0;
    sts_o.pages_full = pages_q >= PCW'(PAGES_PER_TAG);
    sts_o.out_free   = out_free;
  end

  always_comb begin
    res  = '0;
    emit = 1'b1;
    case (cmd_i.op)
      OP_FIN_BEGIN_OPEN: begin
        res.status       = ST_OPEN;
        res.tag_out      = TAG_W'(open_tag_q);
        res.page_count   = PCOUNT_W'(pages_q);
        res.first_offset = OFFSET_W'(held_q);
      end
      OP_FIN_GRANT: begin
        res.status  = ST_OK;
        res.tag_out = TAG_W'(cand_q);
      end
      OP_FIN_NO_TAG: begin
        res.status = ST_NO_TAG;
      end
      OP_FIN_NO_REQ: begin
        res.status = ST_NO_REQ;
      end
      OP_FIN_FAIL: begin
        res.status       = cmd_i.code;
        res.tag_out      = TAG_W'(open_tag_q);
        res.page_count   = PCOUNT_W'(pages_q);
        res.first_offset = OFFSET_W'(held_q);
      end
      OP_FIN_SEG_END: begin
        res.status       = ST_OK;
        res.tag_out      = TAG_W'(open_tag_q);
        res.page_count   = PCOUNT_W'(pages_q);
        res.first_offset = OFFSET_W'(held_q);
        res.request_done = in_q.last_segment;
      end
      OP_FIN_RELEASE: begin
        res.status  = ST_OK;
        res.tag_out = in_q.tag;
      end
      OP_FIN_READ: begin
        res.status       = ST_OK;
        res.tag_out      = in_q.tag;
        res.page_address = rd_ok_q ? {rd_data_q, {OW{1'b0}}} : '0;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= '0;
      last_q      <= '0;
      open_q      <= 1'b0;
      open_tag_q  <= '0;
      pages_q     <= '0;
      seen_q      <= 1'b0;
      held_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      case (cmd_i.op)
        OP_FIN_GRANT: begin
          busy_q[cand_q] <= 1'b1;
          last_q         <= cand_q;
          open_q         <= 1'b1;
          open_tag_q     <= cand_q;
          pages_q        <= '0;
          seen_q         <= 1'b0;
          held_q         <= '0;
        end
        OP_SEG_PREP: begin
          if (!seen_q) begin
            seen_q <= 1'b1;
            held_q <= in_q.seg_address[OW-1:0];
          end
        end
        OP_PAGE_WR: begin
          pages_q <= pages_q + 1'b1;
        end
        OP_FIN_FAIL: begin
          busy_q[open_tag_q] <= 1'b0;
          open_q             <= 1'b0;
        end
        OP_FIN_SEG_END: begin
          if (in_q.last_segment) begin
            open_q <= 1'b0;
          end
        end
        OP_FIN_RELEASE: begin
          if (tag_in_range) begin
            busy_q[tag_lo] <= 1'b0;
            if (open_q && open_tag_q == tag_lo) begin
              open_q <= 1'b0;
            end
          end
        end
        default: begin
        end
      endcase
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LATCH: begin
        in_q <= in_data_i;
      end
      OP_SRCH_INIT: begin
        cand_q <= srch_start;
        cnt_q  <= '0;
      end
      OP_SRCH_STEP: begin
        cand_q <= cand_nx;
        cnt_q  <= cnt_q + 1'b1;
      end
      OP_FIN_GRANT: begin
        base_q <= AW'(cand_q * PAGES_PER_TAG);
      end
      OP_SEG_PREP: begin
        wa_q      <= in_q.seg_address[ADDR_W-1:OW];
        wl_q      <= prep_len;
        mis_q     <= prep_mis;
        len_bad_q <= prep_len_bad;
      end
      OP_PAGE_WR: begin
        wa_q <= wa_q + 1'b1;
        wl_q <= wl_nx;
      end
      OP_RD_ADDR: begin
        rd_addr_q <= AW'(tag_lo * PAGES_PER_TAG) + AW'(in_q.page_index);
        rd_ok_q   <= tag_in_range && page_in_range;
      end
      default: begin
      end
    endcase
    if (emit) begin
      out_q <= res;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_PAGE_WR) begin
      page_mem_q[wr_addr] <= wa_q;
    end
    rd_data_q <= page_mem_q[rd_addr_q];
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_wr_below_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.op == OP_PAGE_WR |-> 32'(pages_q) < PAGES_PER_TAG)
    else $error("page write past the per-tag limit");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> (!out_valid_q || out_ready_i))
    else $error("result loaded over an untaken beat");

  a_open_tag_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    open_q |-> busy_q[open_tag_q])
    else $error("open request holds a free tag");

endmodule

[design/dplb_ctrl.sv]
// Controller: sequences begin, segment, release and read commands.
module dplb_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  dplb_pkg::dplb_sts_t sts_i,
  output dplb_pkg::dplb_cmd_t cmd_o
);
  import dplb_pkg::*;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_DISPATCH = 3'd1;
  localparam logic [2:0] S_SEARCH   = 3'd2;
  localparam logic [2:0] S_SEGCHK   = 3'd3;
  localparam logic [2:0] S_PAGE     = 3'd4;
  localparam logic [2:0] S_RDMEM    = 3'd5;
  localparam logic [2:0] S_FINISH   = 3'd6;

  logic [2:0] state_q, state_d;
  dp_op_e     fin_op_q, fin_op_d;
  status_e    fin_code_q, fin_code_d;

  always_comb begin
    state_d    = state_q;
    fin_op_d   = fin_op_q;
    fin_code_d = fin_code_q;
    cmd_o.op   = OP_NONE;
    cmd_o.code = ST_OK;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_LATCH;
          state_d  = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (sts_i.cmd)
          CMD_BEGIN: begin
            if (sts_i.req_open) begin
              fin_op_d = OP_FIN_BEGIN_OPEN;
              state_d  = S_FINISH;
            end else begin
              cmd_o.op = OP_SRCH_INIT;
              state_d  = S_SEARCH;
            end
          end
          CMD_SEGMENT: begin
            if (!sts_i.req_open) begin
              fin_op_d = OP_FIN_NO_REQ;
              state_d  = S_FINISH;
            end else begin
              cmd_o.op = OP_SEG_PREP;
              state_d  = S_SEGCHK;
            end
          end
          CMD_RELEASE: begin
            fin_op_d = OP_FIN_RELEASE;
            state_d  = S_FINISH;
          end
          CMD_READ: begin
            cmd_o.op = OP_RD_ADDR;
            state_d  = S_RDMEM;
          end
          default: begin
            fin_op_d = OP_FIN_RELEASE;
            state_d  = S_FINISH;
          end
        endcase
      end
      S_SEARCH: begin
        if (sts_i.cand_free) begin
          fin_op_d = OP_FIN_GRANT;
          state_d  = S_FINISH;
        end else if (sts_i.srch_last) begin
          fin_op_d = OP_FIN_NO_TAG;
          state_d  = S_FINISH;
        end else begin
          cmd_o.op = OP_SRCH_STEP;
        end
      end
      S_SEGCHK: begin
        if (sts_i.mis) begin
          fin_op_d   = OP_FIN_FAIL;
          fin_code_d = ST_MISALIGN;
          state_d    = S_FINISH;
        end else if (sts_i.len_bad) begin
          fin_op_d   = OP_FIN_FAIL;
          fin_code_d = ST_LEN;
          state_d    = S_FINISH;
        end else begin
          state_d = S_PAGE;
        end
      end
      S_PAGE: begin
        if (sts_i.len_zero) begin
          fin_op_d = OP_FIN_SEG_END;
          state_d  = S_FINISH;
        end else if (sts_i.pages_full) begin
          fin_op_d   = OP_FIN_FAIL;
          fin_code_d = ST_PAGES;
          state_d    = S_FINISH;
        end else begin
          cmd_o.op = OP_PAGE_WR;
        end
      end
      S_RDMEM: begin
        fin_op_d = OP_FIN_READ;
        state_d  = S_FINISH;
      end
      S_FINISH: begin
        if (sts_i.out_free) begin
          cmd_o.op   = fin_op_q;
          cmd_o.code = fin_code_q;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      fin_op_q   <= OP_NONE;
      fin_code_q <= ST_OK;
    end else begin
      state_q    <= state_d;
      fin_op_q   <= fin_op_d;
      fin_code_q <= fin_code_d;
    end
  end

  assign in_ready_o = state_q == S_IDLE;

  a_walk_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PAGE && !sts_i.len_zero && !sts_i.pages_full) |=> state_q == S_PAGE)
    else $error("page walk stopped early");

  a_finish_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FINISH && !sts_i.out_free)
      |=> (state_q == S_FINISH && $stable(fin_op_q) && $stable(fin_code_q)))
    else $error("pending result dropped while output stalled");

  a_search_closed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SEARCH |-> !sts_i.req_open)
    else $error("tag search with a request open");

endmodule

[design/dma_page_list_builder_with_tags_unit.sv]
// Top level of the DMA page-list builder with next-fit tag allocation.
//
//  channel | direction | handshake             | beat
//  in      | input     | in_valid_i/in_ready_o | in_data_i (in_item_t)
//  out     | output    | out_valid_o/out_ready_i | out_data_o (out_item_t)
//
// One item at a time; one result beat per item.
// Begin: reports an open request if any, else searches tags, one tag probed per cycle.
// Segment: one table entry per page written; errors with no request, misalignment or bad length.
// Release frees the named tag; read goes through the registered page table read.
// Reset clears tag map and request state; the page table needs no clearing pass.
// A stalled output holds the finished result; the next input beat is taken meanwhile.
module dma_page_list_builder_with_tags_unit #(
  parameter int unsigned TAG_COUNT     = dplb_pkg::TAG_COUNT_DEF,
  parameter int unsigned PAGES_PER_TAG = dplb_pkg::PAGES_PER_TAG_DEF,
  parameter int unsigned PAGE_BYTES    = dplb_pkg::PAGE_BYTES_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  dplb_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output dplb_pkg::out_item_t out_data_o
);
  import dplb_pkg::*;

  dplb_cmd_t cmd;
  dplb_sts_t sts;

  dplb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  dplb_datapath #(
    .TAG_COUNT     (TAG_COUNT),
    .PAGES_PER_TAG (PAGES_PER_TAG),
    .PAGE_BYTES    (PAGE_BYTES)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
